/* rtl/rsvp_pkg.sv */
// Package with the shared types and constants of the RSVP session table.
`timescale 1ns / 1ps
`default_nettype none
package rsvp_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int SLOT_W = 8;

    localparam logic [1:0] OP_PATH  = 2'd0;
    localparam logic [1:0] OP_RESV  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_OTHER = 2'd3;

    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_RESV = 2'd1;
    localparam logic [1:0] KIND_PASS = 2'd2;

    localparam logic [1:0] REG_LAN  = 2'd0;
    localparam logic [1:0] REG_WAN  = 2'd1;
    localparam logic [1:0] REG_BIAS = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        from_wan;
        logic [31:0] dst_ip;
        logic [31:0] sender_addr;
        logic [15:0] sender_port;
        logic [15:0] dest_port;
        logic [7:0]  ip_proto;
        logic [31:0] msg_hop;
        logic [31:0] refresh_period;
        logic        has_confirm;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] rewritten_hop;
        logic [31:0] next_hop_addr;
        logic        with_confirm;
        logic [3:0]  entry_index;
        logic        table_full;
    } rsp_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] sender;
        logic [15:0] sender_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
    } key_t;

    typedef struct packed {
        logic              active;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [31:0]       hop;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
    } probe_t;

    typedef struct packed {
        logic              en;
        logic              insert;
        logic [SLOT_W-1:0] idx;
        logic [31:0]       hop;
        logic [31:0]       life;
    } wr_t;

endpackage
`default_nettype wire

/* rtl/rsvp_session_soft_state_table.sv */
// Top level of the RSVP session soft-state table.
// A request is taken when start is high and busy is low; request carries one
// parsed message or a timer tick. busy stays high until the request is done.
// The request is registered, then a probe walks a row of TABLE_DEPTH slot
// cells, one cell per cycle. When the probe leaves the last cell the table
// update for a Path is applied and the result is registered.
// The result strobe rises once the request has passed the launch register, the
// cell row and the result register, and the result is taken at the edge that
// ends the strobe cycle. busy falls as the strobe rises, so a new request can
// be taken in the strobe cycle; the walk of the probe through the cell row sets
// the time that one request takes.
// Results appear on result for exactly one cycle with result_valid high; the
// receiver must take them then. Ticks and unmatched Resv give no result.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data and
// must only be issued while busy is low. cfg_ready is always high.
// Reset clears all slots to invalid and the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module rsvp_session_soft_state_table
    import rsvp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        request,
    output logic             result_valid,
    output rsp_t             result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] lan_reg;
    logic [31:0] wan_reg;
    logic [15:0] bias_reg;
    logic        busy_reg, busy_next;
    logic        launch_reg;
    req_t        req_reg;
    logic [31:0] own_reg;
    logic [31:0] life_reg;
    logic        strobe_reg, strobe_next;
    rsp_t        rsp_reg, rsp_next;
    probe_t      head;
    probe_t      chain [TABLE_DEPTH+1];
    probe_t      tail;
    wr_t         wr;
    key_t        key;
    logic [33:0] life_sum;
    logic        accept;

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;
    assign life_sum  = 34'(bias_reg)
                     + (({2'b00, request.refresh_period}
                        + {1'b0, request.refresh_period, 1'b0} + 34'd1) >> 1);

    always_comb
    begin
        head        = '0;
        head.active = launch_reg;
    end

    assign chain[0] = head;

    assign key = {req_reg.dst_ip, req_reg.sender_addr, req_reg.sender_port,
                  req_reg.dest_port, req_reg.ip_proto};

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            rsvp_cell #(
                .IDX(g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .probe_in (chain[g]),
                .op       (req_reg.operation),
                .key      (key),
                .wr       (wr),
                .probe_out(chain[g+1])
            );
        end
    endgenerate

    assign tail = chain[TABLE_DEPTH];

    always_comb
    begin
        wr          = '0;
        wr.hop      = req_reg.msg_hop;
        wr.life     = life_reg;
        rsp_next    = '0;
        strobe_next = 1'b0;
        busy_next   = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tail.active)
        begin
            busy_next = 1'b0;
            case (req_reg.operation)
                OP_PATH:
                begin
                    strobe_next           = 1'b1;
                    rsp_next.result_kind   = KIND_PATH;
                    rsp_next.rewritten_hop = own_reg;
                    if (tail.hit)
                    begin
                        wr.en                = 1'b1;
                        wr.idx               = tail.hit_idx;
                        rsp_next.entry_index = tail.hit_idx[3:0];
                    end
                    else if (tail.free)
                    begin
                        wr.en                = 1'b1;
                        wr.insert            = 1'b1;
                        wr.idx               = tail.free_idx;
                        rsp_next.entry_index = tail.free_idx[3:0];
                    end
                    else
                    begin
                        rsp_next.table_full = 1'b1;
                    end
                end
                OP_RESV:
                begin
                    if (tail.hit)
                    begin
                        strobe_next            = 1'b1;
                        rsp_next.result_kind   = KIND_RESV;
                        rsp_next.rewritten_hop = own_reg;
                        rsp_next.next_hop_addr = tail.hop;
                        rsp_next.with_confirm  = req_reg.has_confirm;
                        rsp_next.entry_index   = tail.hit_idx[3:0];
                    end
                end
                OP_OTHER:
                begin
                    strobe_next          = 1'b1;
                    rsp_next.result_kind = KIND_PASS;
                end
                default:
                begin
                    strobe_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            strobe_reg <= 1'b0;
            lan_reg    <= 32'd0;
            wan_reg    <= 32'd0;
            bias_reg   <= 16'd3;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= accept;
            strobe_reg <= strobe_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LAN:  lan_reg  <= cfg_data;
                    REG_WAN:  wan_reg  <= cfg_data;
                    REG_BIAS: bias_reg <= cfg_data[15:0];
                    default:  bias_reg <= bias_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg  <= request;
            own_reg  <= request.from_wan ? lan_reg : wan_reg;
            life_reg <= (life_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : life_sum[31:0];
        end
    end

    assign busy         = busy_reg;
    assign result_valid = strobe_reg;
    assign result       = rsp_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> !busy_reg)
        else $error("result strobe while busy");

    a_resv_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rsp_reg.result_kind == KIND_RESV) |-> !rsp_reg.table_full)
        else $error("resv result flagged table full");

    a_tail_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.active |-> busy_reg)
        else $error("probe finished while idle");

endmodule
`default_nettype wire

/* rtl/rsvp_cell.sv */
// One table slot; it checks the passing probe against its entry, ages the entry on a tick and hands the probe on.
`timescale 1ns / 1ps
`default_nettype none
module rsvp_cell
    import rsvp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire probe_t probe_in,
    input  wire logic [1:0] op,
    input  wire key_t   key,
    input  wire wr_t    wr,
    output probe_t      probe_out
);

    logic        valid_reg, valid_next;
    key_t        key_reg, key_next;
    logic [31:0] hop_reg, hop_next;
    logic [31:0] life_reg, life_next;
    probe_t      probe_reg, probe_next;
    logic        match;
    logic [31:0] life_dec;

    assign match = valid_reg && (key_reg == key);
    assign life_dec = life_reg - {31'd0, (life_reg != 32'd0)};

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        hop_next   = hop_reg;
        life_next  = life_reg;
        probe_next = probe_in;
        if (probe_in.active)
        begin
            if (op == OP_TICK)
            begin
                if (valid_reg)
                begin
                    life_next = life_dec;
                    if (life_dec == 32'd0)
                    begin
                        valid_next = 1'b0;
                    end
                end
            end
            if (!probe_in.hit && match)
            begin
                probe_next.hit     = 1'b1;
                probe_next.hit_idx = SLOT_W'(IDX);
                probe_next.hop     = hop_reg;
            end
            if (!probe_in.free && !valid_reg)
            begin
                probe_next.free     = 1'b1;
                probe_next.free_idx = SLOT_W'(IDX);
            end
        end
        if (wr.en && (wr.idx == SLOT_W'(IDX)))
        begin
            if (wr.insert)
            begin
                valid_next = 1'b1;
                key_next   = key;
            end
            hop_next  = wr.hop;
            life_next = wr.life;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        hop_reg  <= hop_next;
        life_reg <= life_next;
    end

    assign probe_out = probe_reg;

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the RSVP session soft-state table.
`timescale 1ns / 1ps
module testbench;
    import rsvp_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REQ_W = $bits(req_t);
    localparam int KEY_W = $bits(key_t);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        request = '0;
    logic        result_valid;
    rsp_t        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rsvp_session_soft_state_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    logic [31:0] own_lan, own_wan;
    logic [15:0] bias;
    logic        slot_live [DEPTH];
    key_t        slot_key [DEPTH];
    logic [31:0] slot_hop [DEPTH];
    logic [31:0] slot_life [DEPTH];
    rsp_t        pending_rsp [$];
    int          errors = 0;
    int          cycles = 0;
    key_t        known_keys [$];

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rsvp_session_soft_state_table regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                rsp_t exp_r;
                exp_r = pending_rsp.pop_front();
                if (exp_r !== result)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, exp_r, result);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] session_lifetime(logic [31:0] period);
        logic [33:0] v;
        v = {18'd0, bias} + (({2'd0, period} * 34'd3 + 34'd1) >> 1);
        return (v > 34'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    task automatic predict_message(req_t r);
        key_t k;
        int   hit;
        rsp_t o;
        k = '{r.dst_ip, r.sender_addr, r.sender_port, r.dest_port, r.ip_proto};
        o = '0;
        hit = -1;
        if (r.operation == OP_TICK)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (slot_live[i])
                begin
                    if (slot_life[i] != 0) slot_life[i]--;
                    if (slot_life[i] == 0) slot_live[i] = 1'b0;
                end
            return;
        end
        if (r.operation == OP_OTHER)
        begin
            o.result_kind = KIND_PASS;
            pending_rsp.push_back(o);
            return;
        end
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && slot_live[i] && slot_key[i] == k) hit = i;
        o.rewritten_hop = r.from_wan ? own_lan : own_wan;
        if (r.operation == OP_RESV)
        begin
            if (hit < 0) return;
            o.result_kind = KIND_RESV;
            o.next_hop_addr = slot_hop[hit];
            o.with_confirm = r.has_confirm;
            o.entry_index = hit[3:0];
            pending_rsp.push_back(o);
            return;
        end
        o.result_kind = KIND_PATH;
        if (hit < 0)
            for (int i = 0; i < DEPTH; i++)
                if (hit < 0 && !slot_live[i])
                begin
                    hit = i;
                    slot_live[i] = 1'b1;
                    slot_key[i] = k;
                end
        if (hit < 0)
            o.table_full = 1'b1;
        else
        begin
            slot_hop[hit] = r.msg_hop;
            slot_life[hit] = session_lifetime(r.refresh_period);
            o.entry_index = hit[3:0];
        end
        pending_rsp.push_back(o);
    endtask

    task automatic send_request(req_t r, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        while (busy) @(negedge clk);
        repeat (gap) @(negedge clk);
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        predict_message(r);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_LAN) own_lan = val;
        else if (idx == REG_WAN) own_wan = val;
        else if (idx == REG_BIAS) bias = val[15:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (busy) @(negedge clk);
        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (DEPTH + 4) @(negedge clk);
    endtask

    function automatic req_t random_fields();
        req_t r;
        r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return r;
    endfunction

    function automatic req_t make_msg(logic [1:0] op, key_t k);
        req_t r;
        r = random_fields();
        r.operation = op;
        {r.dst_ip, r.sender_addr, r.sender_port, r.dest_port, r.ip_proto} = k;
        r.refresh_period = $urandom_range(0, 6);
        return r;
    endfunction

    task automatic configure(logic [31:0] lan, logic [31:0] wan, logic [15:0] b);
        drain_results();
        write_reg(REG_LAN, lan);
        write_reg(REG_WAN, wan);
        write_reg(REG_BIAS, {16'd0, b});
    endtask

    task automatic test_directed();
        req_t r;
        key_t k;
        configure(32'hFFFFFFFF, 32'h0, 16'd0);
        k = '1;
        r = make_msg(OP_PATH, k);
        r.refresh_period = 32'hFFFFFFFF;
        r.msg_hop = '1;
        send_request(r);
        r = make_msg(OP_RESV, k);
        r.from_wan = 1'b1;
        r.has_confirm = 1'b1;
        send_request(r);
        r = make_msg(OP_RESV, '0);
        send_request(r);
        r = '0;
        r.operation = OP_OTHER;
        send_request(r);
        r = '0;
        send_request(r);
        r.refresh_period = 0;
        r.operation = OP_TICK;
        send_request(r);
        r = '0;
        send_request(r);
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            k = '{i, 32'h1, 16'h2, 16'h3, 8'h4};
            r = make_msg(OP_PATH, k);
            send_request(r, 1);
        end
        r = '0;
        r.operation = OP_TICK;
        send_request(r);
    endtask

    task automatic test_random(int count, int tick_pct);
        req_t r;
        key_t k;
        int   pick;
        for (int n = 0; n < count; n++)
        begin
            if (known_keys.size() == 0 || $urandom_range(0, 3) == 0)
            begin
                k = KEY_W'({$urandom, $urandom, $urandom, $urandom});
                known_keys.push_back(k);
                if (known_keys.size() > 24) void'(known_keys.pop_front());
            end
            else
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) r = make_msg(OP_TICK, k);
            else if (pick < 50) r = make_msg(OP_PATH, k);
            else if (pick < 85) r = make_msg(OP_RESV, k);
            else if (pick < 92) r = make_msg(OP_OTHER, k);
            else r = random_fields();
            send_request(r, $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        own_lan = '0;
        own_wan = '0;
        bias = 16'd3;
        for (int i = 0; i < DEPTH; i++) slot_live[i] = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        configure($urandom, $urandom, 16'd0);
        test_random(250, 20);
        configure($urandom, $urandom, 16'hFFFF);
        test_random(150, 15);
        configure($urandom, $urandom, 16'($urandom_range(0, 4)));
        test_random(350, 30);
        drain_results();
        if (errors == 0)
            $display("rsvp_session_soft_state_table regression: pass");
        else
            $display("rsvp_session_soft_state_table regression: fail");
        $finish;
    end
endmodule
